### design/mhpq_pkg.sv
`timescale 1ns / 1ps
package mhpq_pkg;
  localparam int CAPACITY = 64;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IDW = 27;
  localparam int PW = 16;
  localparam int EW = IDW + PW;

  typedef logic [1:0] op_t;
  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_PROMOTE = 2'd1;
  localparam op_t OP_EXTRACT = 2'd2;
  localparam op_t OP_PEEK = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL = 2'd2;
  localparam status_t ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [IDW-1:0] ident;
    logic signed [PW-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic we;
    logic [AW-1:0] waddr;
    entry_t wdata;
    logic [AW-1:0] raddr;
  } mem_req_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ROOT, S_SRCH, S_UPRD, S_UPCMP, S_UPWR, S_DNRD, S_DNL, S_DNR, S_DNCMP,
    S_DNWR, S_OUT
  } state_t;

  function automatic logic signed [PW-1:0] sat_add(
    input logic signed [PW-1:0] a, input logic signed [PW-1:0] b);
    logic signed [PW:0] s;
    s = {a[PW-1], a} + {b[PW-1], b};
    if (s[PW] != s[PW-1]) begin
      sat_add = s[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
    end else begin
      sat_add = s[PW-1:0];
    end
  endfunction
endpackage

### design/mhpq_ram.sv
`timescale 1ns / 1ps
module mhpq_ram (
  input  logic clk,
  input  mhpq_pkg::mem_req_t req,
  output mhpq_pkg::entry_t rdata
);
  import mhpq_pkg::*;
  entry_t mem [CAPACITY];
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end
endmodule

### design/mhpq_ctrl.sv
`timescale 1ns / 1ps
module mhpq_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [47:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  output logic [47:0] out_tdata,
  output mhpq_pkg::mem_req_t req,
  input  mhpq_pkg::entry_t rdata
);
  import mhpq_pkg::*;
  state_t state_r, state_nxt;
  op_t op_r, op_nxt;
  logic [IDW-1:0] id_r, id_nxt;
  logic signed [PW-1:0] amt_r, amt_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  entry_t cur_r, cur_nxt, ch_r, ch_nxt;
  logic [CW:0] best_r, best_nxt;
  status_t st_r, st_nxt;
  entry_t top_r, top_nxt;
  logic ov_r, ov_nxt;
  logic [CW:0] lft;
  logic [AW-1:0] par;

  assign in_tready = (state_r == S_IDLE) && !ov_r;
  assign out_tvalid = ov_r;
  assign out_tdata = {3'b0, top_r.prio, top_r.ident, st_r};
  assign lft = {pos_r, 1'b1};
  assign par = AW'((pos_r - 1'b1) >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      ov_r <= ov_nxt;
    end
    op_r <= op_nxt; id_r <= id_nxt; amt_r <= amt_nxt; pos_r <= pos_nxt;
    cur_r <= cur_nxt; ch_r <= ch_nxt; best_r <= best_nxt; st_r <= st_nxt;
    top_r <= top_nxt;
  end

  always_comb begin
    state_nxt = state_r; op_nxt = op_r; id_nxt = id_r; amt_nxt = amt_r;
    cnt_nxt = cnt_r; pos_nxt = pos_r; cur_nxt = cur_r; ch_nxt = ch_r;
    best_nxt = best_r; st_nxt = st_r; top_nxt = top_r; ov_nxt = ov_r;
    req = '0;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          op_nxt = in_tdata[1:0];
          id_nxt = in_tdata[28:2];
          amt_nxt = in_tdata[44:29];
          st_nxt = ST_OK;
          top_nxt = '0;
          pos_nxt = '0;
          req.raddr = '0;
          unique case (in_tdata[1:0])
            OP_INSERT: begin
              if (cnt_r == CW'(CAPACITY)) begin
                st_nxt = ST_FULL; state_nxt = S_OUT;
              end else begin
                req.we = 1'b1;
                req.waddr = AW'(cnt_r);
                req.wdata = '{ident: in_tdata[28:2], prio: in_tdata[44:29]};
                cur_nxt = req.wdata;
                pos_nxt = cnt_r;
                cnt_nxt = cnt_r + 1'b1;
                state_nxt = S_UPRD;
              end
            end
            OP_PROMOTE: begin
              if (cnt_r == '0) begin
                st_nxt = ST_NOTFOUND; state_nxt = S_OUT;
              end else state_nxt = S_SRCH;
            end
            default: begin
              if (cnt_r == '0) begin
                st_nxt = ST_EMPTY; state_nxt = S_OUT;
              end else state_nxt = S_ROOT;
            end
          endcase
        end
      end
      S_ROOT: begin
        top_nxt = rdata;
        if (op_r == OP_EXTRACT) begin
          cur_nxt = '{ident: rdata.ident, prio: '0};
          req.we = 1'b1; req.waddr = '0; req.wdata = cur_nxt;
          state_nxt = S_DNRD;
        end else state_nxt = S_OUT;
      end
      S_SRCH: begin
        if (rdata.ident == id_r) begin
          cur_nxt = '{ident: rdata.ident, prio: sat_add(rdata.prio, amt_r)};
          req.we = 1'b1; req.waddr = AW'(pos_r); req.wdata = cur_nxt;
          state_nxt = S_UPRD;
        end else if (pos_r + 1'b1 >= cnt_r) begin
          st_nxt = ST_NOTFOUND; state_nxt = S_OUT;
        end else begin
          pos_nxt = pos_r + 1'b1;
          req.raddr = AW'(pos_r + 1'b1);
        end
      end
      S_UPRD: begin
        if (pos_r == '0) state_nxt = S_OUT;
        else begin
          req.raddr = par; state_nxt = S_UPCMP;
        end
      end
      S_UPCMP: begin
        if (cur_r.prio <= rdata.prio) state_nxt = S_OUT;
        else begin
          req.we = 1'b1; req.waddr = AW'(pos_r); req.wdata = rdata;
          pos_nxt = CW'(par);
          state_nxt = S_UPWR;
        end
      end
      S_UPWR: begin
        req.we = 1'b1; req.waddr = AW'(pos_r); req.wdata = cur_r;
        state_nxt = S_UPRD;
      end
      S_DNRD: begin
        best_nxt = {1'b0, pos_r};
        ch_nxt = cur_r;
        if (lft >= {1'b0, cnt_r}) state_nxt = S_OUT;
        else begin
          req.raddr = AW'(lft); state_nxt = S_DNL;
        end
      end
      S_DNL: begin
        if (rdata.prio > ch_r.prio) begin
          ch_nxt = rdata; best_nxt = lft;
        end
        if (lft + 1'b1 < {1'b0, cnt_r}) begin
          req.raddr = AW'(lft + 1'b1); state_nxt = S_DNR;
        end else state_nxt = S_DNCMP;
      end
      S_DNR: begin
        if (rdata.prio > ch_r.prio) begin
          ch_nxt = rdata; best_nxt = lft + 1'b1;
        end
        state_nxt = S_DNCMP;
      end
      S_DNCMP: begin
        if (best_r == {1'b0, pos_r}) state_nxt = S_OUT;
        else begin
          req.we = 1'b1; req.waddr = AW'(pos_r); req.wdata = ch_r;
          pos_nxt = CW'(best_r);
          state_nxt = S_DNWR;
        end
      end
      S_DNWR: begin
        req.we = 1'b1; req.waddr = AW'(pos_r); req.wdata = cur_r;
        state_nxt = S_DNRD;
      end
      S_OUT: begin
        if (!ov_r) begin
          ov_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

### design/max_heap_priority_queue_core.sv
`timescale 1ns / 1ps
// Binary max-heap of 64 entries (27-bit identifier, signed 16-bit priority) in
// one synchronous RAM, one operation per input transfer and one result transfer
// each. Peek reads the root, insert climbs level by level, extract descends
// level by level, and promote scans the entries one at a time in array order
// and then climbs. Every step goes through the single RAM port pair. A new item
// is taken once the previous result has been transferred.
module max_heap_priority_queue_core (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [47:0] in_tdata,    // op[1:0], ident[28:2], amount[44:29]
  output logic out_tvalid,
  input  logic out_tready,
  output logic [47:0] out_tdata    // status[1:0], top_ident[28:2], top_priority[44:29]
);
  import mhpq_pkg::*;
  mem_req_t req;
  entry_t rdata;
  mhpq_ram u_ram (.clk(clk), .req(req), .rdata(rdata));
  mhpq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .req(req), .rdata(rdata)
  );
endmodule

### design/mhpq_chk.sv
`timescale 1ns / 1ps
module mhpq_chk (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [47:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("hold");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("one in flight");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != 2'd0 |-> out_tdata[44:2] == '0) else $error("zero");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[47:45] == 3'b0) else $error("pad");
endmodule

bind max_heap_priority_queue_core mhpq_chk u_chk (.*);
